// File: rtl/sle_pkg.sv
// Package for the sequential list engine.
// Holds command and status codes, stream field layout and the control structs.
// No dependencies.
package sle_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STS_W   = 2;
    localparam int LEN_W   = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam int S_POS_LSB   = 0;
    localparam int S_VALUE_LSB = S_POS_LSB + POS_W;
    localparam int S_USED_W    = S_VALUE_LSB + VALUE_W;

    localparam int M_STS_LSB   = 0;
    localparam int M_ELEM_LSB  = M_STS_LSB + STS_W;
    localparam int M_FOUND_LSB = M_ELEM_LSB + VALUE_W;
    localparam int M_LEN_LSB   = M_FOUND_LSB + LEN_W;
    localparam int M_USED_W    = M_LEN_LSB + LEN_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_LOCATE = 3'd4
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } sts_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic walk;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/sle_ctrl.sv
// Controller state machine of the sequential list engine.
// Sequences load, setup, memory walk and result commit; depends on sle_pkg.
module sle_ctrl
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SETUP  = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        dp_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                dp_cmd.setup = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                dp_cmd.walk = 1'b1;
                if (dp_status.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sle_dp.sv
// Datapath of the sequential list engine: entry memory, length, walk counters,
// bounds checks and the output register; depends on sle_pkg.
module sle_dp
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              dp_cmd,
    output dp_status_t           dp_status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CMD_W-1:0]          cmd_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] val_reg;
    sts_t                      sts_reg;
    sts_t                      sts_next;
    logic signed [VALUE_W-1:0] elem_reg;
    logic signed [VALUE_W-1:0] elem_next;
    logic [LEN_W-1:0]          found_reg;
    logic [LEN_W-1:0]          found_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [AW-1:0]             walk_addr_reg;
    logic [AW-1:0]             walk_addr_next;
    logic [CW-1:0]             walk_left_reg;
    logic [CW-1:0]             walk_left_next;
    logic                      walk_down_reg;
    logic                      walk_down_next;
    logic                      rd_en;
    logic                      rd_vld_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      out_valid_reg;
    logic [M_TDATA_W-1:0]      out_data_reg;
    logic [M_TDATA_W-1:0]      out_data_next;

    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] pos_x;
    logic            ins_bad;
    logic            acc_bad;
    logic [CW-1:0]   span;
    logic [AW-1:0]   first_idx;
    logic [AW-1:0]   last_idx;

    assign cnt_x     = CMPW'(count_reg);
    assign pos_x     = CMPW'(pos_reg);
    assign ins_bad   = (pos_reg == '0) || (pos_x > cnt_x + CMPW'(1));
    assign acc_bad   = (pos_reg == '0) || (pos_x > cnt_x);
    assign span      = CW'(cnt_x - pos_x + CMPW'(1));
    assign first_idx = AW'(pos_x - CMPW'(1));
    assign last_idx  = AW'(cnt_x - CMPW'(1));

    assign rd_en = dp_cmd.walk && (walk_left_reg != '0);

    assign dp_status.walk_done = (walk_left_reg == '0);
    assign dp_status.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        sts_next       = sts_reg;
        walk_addr_next = walk_addr_reg;
        walk_left_next = walk_left_reg;
        walk_down_next = walk_down_reg;
        if (dp_cmd.setup)
        begin
            sts_next       = STS_OK;
            walk_addr_next = '0;
            walk_left_next = '0;
            walk_down_next = 1'b0;
            case (cmd_reg) inside
                CMD_INSERT:
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        sts_next = STS_FULL;
                    end
                    else if (ins_bad)
                    begin
                        sts_next = STS_RANGE;
                    end
                    else
                    begin
                        walk_addr_next = last_idx;
                        walk_left_next = span;
                        walk_down_next = 1'b1;
                    end
                end
                CMD_DELETE, CMD_GET:
                begin
                    if (count_reg == '0)
                    begin
                        sts_next = STS_EMPTY;
                    end
                    else if (acc_bad)
                    begin
                        sts_next = STS_RANGE;
                    end
                    else
                    begin
                        walk_addr_next = first_idx;
                        walk_left_next = (cmd_reg == CMD_GET) ? CW'(1) : span;
                    end
                end
                CMD_LOCATE:
                begin
                    walk_left_next = count_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (rd_en)
        begin
            walk_left_next = walk_left_reg - CW'(1);
            walk_addr_next = walk_down_reg ? (walk_addr_reg - AW'(1))
                                           : (walk_addr_reg + AW'(1));
        end
    end

    always_comb
    begin
        elem_next  = elem_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        wr_en      = 1'b0;
        wr_addr    = rd_idx_reg;
        wr_data    = rd_data_reg;
        count_next = count_reg;
        if (dp_cmd.setup)
        begin
            elem_next  = '0;
            found_next = '0;
            hit_next   = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + AW'(1);
                end
                CMD_DELETE:
                begin
                    if (rd_idx_reg == first_idx)
                    begin
                        elem_next = rd_data_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg - AW'(1);
                    end
                end
                CMD_GET:
                begin
                    elem_next = rd_data_reg;
                end
                CMD_LOCATE:
                begin
                    if (!hit_reg && (rd_data_reg == val_reg))
                    begin
                        hit_next   = 1'b1;
                        found_next = LEN_W'({1'b0, rd_idx_reg} + (AW + 1)'(1));
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (dp_cmd.finish)
        begin
            if (cmd_reg == CMD_CLEAR)
            begin
                count_next = '0;
            end
            else if (sts_reg == STS_OK)
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = first_idx;
                    wr_data    = val_reg;
                    count_next = count_reg + CW'(1);
                end
                else if (cmd_reg == CMD_DELETE)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[M_STS_LSB +: STS_W]     = sts_reg;
        out_data_next[M_ELEM_LSB +: VALUE_W]  = elem_reg;
        out_data_next[M_FOUND_LSB +: LEN_W]   = found_reg;
        out_data_next[M_LEN_LSB +: LEN_W]     = LEN_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[walk_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= s_tuser;
            pos_reg <= s_tdata[S_POS_LSB +: POS_W];
            val_reg <= s_tdata[S_VALUE_LSB +: VALUE_W];
        end
        if (rd_en)
        begin
            rd_idx_reg <= walk_addr_reg;
        end
        if (dp_cmd.finish)
        begin
            out_data_reg <= out_data_next;
        end
        sts_reg       <= sts_next;
        elem_reg      <= elem_next;
        found_reg     <= found_next;
        hit_reg       <= hit_next;
        walk_addr_reg <= walk_addr_next;
        walk_down_reg <= walk_down_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            walk_left_reg <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            walk_left_reg <= walk_left_next;
            rd_vld_reg    <= rd_en;
            if (dp_cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/sequential_list_engine.sv
// Top level of the sequential list engine.
// Joins the controller sle_ctrl and the datapath sle_dp; depends on sle_pkg.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-read, single-port-write memory and answers each request with one
// result. A request passes through the setup, walk and finish states after
// acceptance, and the walk makes n memory reads: the entries from the position
// to the end for insert and delete, one for get, the whole length for locate and
// none for clear, refused or unknown requests. The memory walk reads one entry
// per cycle, and the finish state waits until the output register is free.
// A new request is taken while the previous result still waits on the output.
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // position[4:0], value[36:5], zero fill
    input  logic [CMD_W-1:0]     s_tuser,  // command[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], element[33:2],
                                           // found_position[38:34],
                                           // list_length[43:39], zero fill
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

endmodule

// File: rtl/sle_checker.sv
// Port-level checker for the sequential list engine, bound to its top level.
// Depends on sle_pkg.
module sle_checker
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STS_W-1:0]   out_sts;
    logic [VALUE_W-1:0] out_elem;
    logic [LEN_W-1:0]   out_found;
    logic [LEN_W-1:0]   out_len;

    assign out_sts   = m_tdata[M_STS_LSB +: STS_W];
    assign out_elem  = m_tdata[M_ELEM_LSB +: VALUE_W];
    assign out_found = m_tdata[M_FOUND_LSB +: LEN_W];
    assign out_len   = m_tdata[M_LEN_LSB +: LEN_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Request accepted while another is in progress.");

    a_refused_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_sts != STS_OK) |-> (out_elem == '0) && (out_found == '0))
        else $error("Refused request carries element or position.");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 31) || (int'(out_len) <= CAPACITY))
        else $error("Reported length exceeds capacity.");

    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_found != '0) |-> (CAPACITY > 31) || (out_found <= out_len))
        else $error("Located position beyond list length.");

endmodule

bind sequential_list_engine sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
